/* hdl/msfs_pkg.sv */
// ============================================================================
// msfs_pkg
// Shared types and constants for the multichannel semblance / F-statistic
// block: fixed widths, result codes, register indexes and FSM encoding.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package msfs_pkg;

    // Window totals wrap modulo 2^64
    localparam int TOT_W  = 64;
    localparam int FILL_W = 9;
    localparam int HW_W   = 7;
    localparam int NC_W   = 4;
    localparam int WIN_W  = 8;
    localparam int SEMB_W = 16;
    localparam int F_W    = 24;
    localparam int POS_W  = 5;

    // Quotient bits below the overflow test position
    localparam int SEMB_FRAC = 15;
    localparam int F_QBITS   = 24;

    // Shifted divisor needs room for the largest quotient position
    localparam int DSH_W = TOT_W + F_QBITS;

    localparam logic [FILL_W-1:0] FILL_MAX = 9'd511;
    localparam logic [SEMB_W-1:0] SEMB_ONE = 16'd32768;
    localparam logic [F_W-1:0]    F_MAX    = 24'hFF_FFFF;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_WINDOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS = 1'b1;

    localparam logic [HW_W-1:0] HW_RESET = 7'd10;
    localparam logic [NC_W-1:0] NC_RESET = 4'd4;

    // Sequencer states, one-hot
    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_SQR  = 11'b000_0000_0010,
        S_ACC  = 11'b000_0000_0100,
        S_STEP = 11'b000_0000_1000,
        S_SUB  = 11'b000_0001_0000,
        S_ADD  = 11'b000_0010_0000,
        S_PREP = 11'b000_0100_0000,
        S_CHK  = 11'b000_1000_0000,
        S_SDIV = 11'b001_0000_0000,
        S_FDIV = 11'b010_0000_0000,
        S_OUT  = 11'b100_0000_0000
    } state_t;

endpackage

`default_nettype wire

/* hdl/multichannel_semblance_fstat.sv */
// ============================================================================
// multichannel_semblance_fstat
// Moving-window semblance (Q1.15) and F-statistic (Q16.8) over time-aligned
// multichannel samples, with per-step values kept in a ring RAM.
// ============================================================================
// Samples enter one channel per beat, in channel order; num_channels beats
// make one time step. A beat that does not close a step runs the sample
// square and energy accumulate states. A beat that closes a step also runs
// step square with a ring RAM read of the outgoing step, subtract and add,
// and, once the window is full, a result follows: setup states S_PREP and
// S_CHK, then a shared restoring divider that retires one quotient bit per
// cycle, first for semblance and then for F, and S_OUT to load the output
// register. An empty or saturated window skips the divider. The result
// register lets the next sample in while a result waits. The ring RAM is
// not cleared; segment_start resets the fill count so stale ones go unused.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_semblance_fstat #(
    parameter int MAX_WINDOW   = 256,
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [msfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [msfs_pkg::CFG_DATA_W-1:0]   cfg_data,
    // sample channel
    input  wire logic                              item_valid,
    output logic                                   item_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]     sample,
    input  wire logic                              segment_start,
    // result channel
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output logic [msfs_pkg::SEMB_W-1:0]            semblance,
    output logic [msfs_pkg::F_W-1:0]               f_statistic,
    output logic                                   f_saturated,
    output logic                                   empty_window
);

    import msfs_pkg::*;

    localparam int CH_BITS = $clog2(MAX_CHANNELS);
    localparam int SS_W    = SAMPLE_BITS + CH_BITS;
    localparam int SQ_W    = 2 * SS_W - 1;
    localparam int XSQ_W   = 2 * SAMPLE_BITS - 1;
    localparam int EN_W    = XSQ_W + CH_BITS;
    localparam int CI_W    = (CH_BITS > 0) ? CH_BITS : 1;
    localparam int PTR_W   = $clog2(MAX_WINDOW);
    localparam int OA_W    = ((PTR_W > WIN_W) ? PTR_W : WIN_W) + 1;
    localparam int RAM_W   = SQ_W + EN_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                  state_reg, state_next;
    logic [HW_W-1:0]         hw_reg, hw_next;
    logic [NC_W-1:0]         nc_reg, nc_next;
    logic signed [SS_W-1:0]  step_sum_reg, step_sum_next;
    logic [EN_W-1:0]         step_en_reg, step_en_next;
    logic [CI_W-1:0]         ci_reg, ci_next;
    logic [PTR_W-1:0]        ptr_reg, ptr_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic [TOT_W-1:0]        num_reg, num_next;
    logic [TOT_W-1:0]        den_reg, den_next;
    logic                    rvalid_reg, rvalid_next;

    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic                    seg_reg, seg_next;
    logic [XSQ_W-1:0]        xsq_reg, xsq_next;
    logic [SQ_W-1:0]         new_sq_reg, new_sq_next;
    logic [EN_W-1:0]         new_en_reg, new_en_next;
    logic                    sub_reg, sub_next;
    logic [TOT_W-1:0]        nd_reg, nd_next;
    logic [TOT_W-1:0]        fdvd_reg, fdvd_next;
    logic [TOT_W-1:0]        fdsor_reg, fdsor_next;
    logic [TOT_W-1:0]        div_rem_reg, div_rem_next;
    logic [DSH_W-1:0]        div_dsh_reg, div_dsh_next;
    logic [F_W-1:0]          div_q_reg, div_q_next;
    logic [POS_W-1:0]        div_pos_reg, div_pos_next;
    logic [SEMB_W-1:0]       res_semb_reg, res_semb_next;
    logic [F_W-1:0]          res_f_reg, res_f_next;
    logic                    res_sat_reg, res_sat_next;
    logic                    res_empty_reg, res_empty_next;
    logic [SEMB_W-1:0]       semb_out_reg, semb_out_next;
    logic [F_W-1:0]          f_out_reg, f_out_next;
    logic                    sat_out_reg, sat_out_next;
    logic                    empty_out_reg, empty_out_next;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic [NC_W-1:0]              n_eff;
    logic [HW_W-1:0]              hw_eff;
    logic [WIN_W-1:0]             w_raw;
    logic [WIN_W-1:0]             w_eff;
    logic [OA_W-1:0]              ptr_w;
    logic [OA_W-1:0]              win_w;
    logic [OA_W-1:0]              old_w;
    logic [PTR_W-1:0]             old_addr;
    logic [PTR_W-1:0]             ptr_inc;
    logic [FILL_W-1:0]            fill_inc;
    logic signed [2*SAMPLE_BITS-1:0] x_sq_full;
    logic signed [2*SS_W-1:0]     ss_sq_full;
    logic [TOT_W-1:0]             nm1_prod;
    logic                         item_acc;
    logic                         ram_wr_en;
    logic                         ram_rd_en;
    logic [RAM_W-1:0]             ram_rd_data;
    logic [SQ_W-1:0]              old_sq;
    logic [EN_W-1:0]              old_en;
    logic                         div_ge;
    logic [F_W-1:0]               div_q_shift;
    logic [TOT_W-1:0]             div_rem_sub;
    logic                         out_free;

    assign cfg_ready    = 1'b1;
    assign item_stall   = (state_reg != S_IDLE);
    assign item_acc     = item_valid && !item_stall;
    assign result_valid = rvalid_reg;
    assign semblance    = semb_out_reg;
    assign f_statistic  = f_out_reg;
    assign f_saturated  = sat_out_reg;
    assign empty_window = empty_out_reg;
    assign out_free     = !rvalid_reg || !result_stall;

    // Effective channel count: zero counts as one, capped at the maximum
    always_comb
    begin
        if (nc_reg == '0)
        begin
            n_eff = NC_W'(1);
        end
        else if (32'(nc_reg) > MAX_CHANNELS)
        begin
            n_eff = NC_W'(MAX_CHANNELS);
        end
        else
        begin
            n_eff = nc_reg;
        end
    end

    // Window length: 2*hw+1, hw of zero counts as one, capped at ring depth
    assign hw_eff = (hw_reg == '0) ? HW_W'(1) : hw_reg;
    assign w_raw  = {hw_eff, 1'b1};
    assign w_eff  = (32'(w_raw) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW) : w_raw;

    // Ring slot of the step leaving the window
    assign ptr_w    = OA_W'(ptr_reg);
    assign win_w    = OA_W'(w_eff);
    assign old_w    = (ptr_w >= win_w) ? (ptr_w - win_w)
                                       : (ptr_w + OA_W'(MAX_WINDOW) - win_w);
    assign old_addr = old_w[PTR_W-1:0];
    assign ptr_inc  = (ptr_reg == PTR_W'(MAX_WINDOW - 1)) ? '0 : ptr_reg + 1'b1;
    assign fill_inc = (fill_reg == FILL_MAX) ? fill_reg : fill_reg + 1'b1;

    // Squarers and small channel-count products
    assign x_sq_full  = x_reg * x_reg;
    assign ss_sq_full = step_sum_reg * step_sum_reg;
    assign nm1_prod   = num_reg * TOT_W'(n_eff - 1'b1);

    // Ring RAM: one word per step, {step sum squared, step energy}
    assign ram_wr_en = (state_reg == S_SUB);
    assign ram_rd_en = (state_reg == S_STEP);
    assign old_sq    = ram_rd_data[RAM_W-1:EN_W];
    assign old_en    = ram_rd_data[EN_W-1:0];

    msfs_ram #(
        .DATA_W (RAM_W),
        .DEPTH  (MAX_WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ptr_reg),
        .wr_data ({new_sq_reg, new_en_reg}),
        .rd_en   (ram_rd_en),
        .rd_addr (old_addr),
        .rd_data (ram_rd_data)
    );

    // Restoring divider datapath: one quotient bit per cycle
    assign div_ge      = (DSH_W'(div_rem_reg) >= div_dsh_reg);
    assign div_q_shift = {div_q_reg[F_W-2:0], div_ge};
    assign div_rem_sub = div_rem_reg - div_dsh_reg[TOT_W-1:0];

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        hw_next        = hw_reg;
        nc_next        = nc_reg;
        step_sum_next  = step_sum_reg;
        step_en_next   = step_en_reg;
        ci_next        = ci_reg;
        ptr_next       = ptr_reg;
        fill_next      = fill_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        rvalid_next    = rvalid_reg;
        x_next         = x_reg;
        seg_next       = seg_reg;
        xsq_next       = xsq_reg;
        new_sq_next    = new_sq_reg;
        new_en_next    = new_en_reg;
        sub_next       = sub_reg;
        nd_next        = nd_reg;
        fdvd_next      = fdvd_reg;
        fdsor_next     = fdsor_reg;
        div_rem_next   = div_rem_reg;
        div_dsh_next   = div_dsh_reg;
        div_q_next     = div_q_reg;
        div_pos_next   = div_pos_reg;
        res_semb_next  = res_semb_reg;
        res_f_next     = res_f_reg;
        res_sat_next   = res_sat_reg;
        res_empty_next = res_empty_reg;
        semb_out_next  = semb_out_reg;
        f_out_next     = f_out_reg;
        sat_out_next   = sat_out_reg;
        empty_out_next = empty_out_reg;

        // Configuration writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_HALF_WINDOW:  hw_next = cfg_data[HW_W-1:0];
                REG_NUM_CHANNELS: nc_next = cfg_data[NC_W-1:0];
            endcase
        end

        // Result register drains on a taken beat
        if (rvalid_reg && !result_stall)
        begin
            rvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_acc)
                begin
                    x_next     = sample;
                    seg_next   = segment_start;
                    state_next = S_SQR;
                end
            end

            // Sample square; segment start clears the window first
            S_SQR:
            begin
                xsq_next = x_sq_full[XSQ_W-1:0];
                if (seg_reg)
                begin
                    step_sum_next = SS_W'(x_reg);
                    step_en_next  = '0;
                    ci_next       = '0;
                    ptr_next      = '0;
                    fill_next     = '0;
                    num_next      = '0;
                    den_next      = '0;
                end
                else
                begin
                    step_sum_next = step_sum_reg + SS_W'(x_reg);
                end
                state_next = S_ACC;
            end

            // Energy accumulate and channel count
            S_ACC:
            begin
                step_en_next = step_en_reg + EN_W'(xsq_reg);
                if ((8'(ci_reg) + 8'd1) < 8'(n_eff))
                begin
                    ci_next    = ci_reg + 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ci_next    = '0;
                    state_next = S_STEP;
                end
            end

            // Close the step, fetch the outgoing ring entry
            S_STEP:
            begin
                new_sq_next   = ss_sq_full[SQ_W-1:0];
                new_en_next   = step_en_reg;
                step_sum_next = '0;
                step_en_next  = '0;
                sub_next      = (fill_reg >= FILL_W'(w_eff));
                state_next    = S_SUB;
            end

            // Drop the outgoing step, store the new one
            S_SUB:
            begin
                if (sub_reg)
                begin
                    num_next = num_reg - TOT_W'(old_sq);
                    den_next = den_reg - TOT_W'(old_en);
                end
                state_next = S_ADD;
            end

            S_ADD:
            begin
                num_next  = num_reg + TOT_W'(new_sq_reg);
                den_next  = den_reg + TOT_W'(new_en_reg);
                ptr_next  = ptr_inc;
                fill_next = fill_inc;
                if (fill_inc >= FILL_W'(w_eff))
                begin
                    state_next = S_PREP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            // n*D and the F dividend N*(n-1)*256
            S_PREP:
            begin
                nd_next    = den_reg * TOT_W'(n_eff);
                fdvd_next  = {nm1_prod[TOT_W-9:0], 8'b0};
                state_next = S_CHK;
            end

            // Empty and unit-semblance windows skip the divider
            S_CHK:
            begin
                res_empty_next = 1'b0;
                if (den_reg == '0)
                begin
                    res_empty_next = 1'b1;
                    res_semb_next  = '0;
                    res_f_next     = '0;
                    res_sat_next   = 1'b0;
                    state_next     = S_OUT;
                end
                else if (num_reg >= nd_reg)
                begin
                    res_semb_next = SEMB_ONE;
                    res_f_next    = F_MAX;
                    res_sat_next  = 1'b1;
                    state_next    = S_OUT;
                end
                else
                begin
                    fdsor_next   = nd_reg - num_reg;
                    div_rem_next = num_reg << SEMB_FRAC;
                    div_dsh_next = DSH_W'(nd_reg) << SEMB_FRAC;
                    div_pos_next = POS_W'(SEMB_FRAC);
                    div_q_next   = '0;
                    state_next   = S_SDIV;
                end
            end

            // Semblance quotient; top position is the overflow test
            S_SDIV:
            begin
                if (div_pos_reg == POS_W'(SEMB_FRAC))
                begin
                    if (div_ge)
                    begin
                        res_semb_next = SEMB_ONE;
                        div_rem_next  = fdvd_reg;
                        div_dsh_next  = DSH_W'(fdsor_reg) << F_QBITS;
                        div_pos_next  = POS_W'(F_QBITS);
                        div_q_next    = '0;
                        state_next    = S_FDIV;
                    end
                    else
                    begin
                        div_dsh_next = div_dsh_reg >> 1;
                        div_pos_next = div_pos_reg - 1'b1;
                    end
                end
                else
                begin
                    if (div_ge)
                    begin
                        div_rem_next = div_rem_sub;
                    end
                    div_q_next = div_q_shift;
                    if (div_pos_reg == '0)
                    begin
                        res_semb_next = SEMB_W'(div_q_shift[SEMB_FRAC-1:0]);
                        div_rem_next  = fdvd_reg;
                        div_dsh_next  = DSH_W'(fdsor_reg) << F_QBITS;
                        div_pos_next  = POS_W'(F_QBITS);
                        div_q_next    = '0;
                        state_next    = S_FDIV;
                    end
                    else
                    begin
                        div_dsh_next = div_dsh_reg >> 1;
                        div_pos_next = div_pos_reg - 1'b1;
                    end
                end
            end

            // F quotient; an overflow at the top position saturates
            S_FDIV:
            begin
                if (div_pos_reg == POS_W'(F_QBITS))
                begin
                    if (div_ge)
                    begin
                        res_f_next   = F_MAX;
                        res_sat_next = 1'b1;
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        div_dsh_next = div_dsh_reg >> 1;
                        div_pos_next = div_pos_reg - 1'b1;
                    end
                end
                else
                begin
                    if (div_ge)
                    begin
                        div_rem_next = div_rem_sub;
                    end
                    div_q_next = div_q_shift;
                    if (div_pos_reg == '0)
                    begin
                        res_f_next   = div_q_shift;
                        res_sat_next = 1'b0;
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        div_dsh_next = div_dsh_reg >> 1;
                        div_pos_next = div_pos_reg - 1'b1;
                    end
                end
            end

            // Hand the result to the output register when it is free
            S_OUT:
            begin
                if (out_free)
                begin
                    semb_out_next  = res_semb_reg;
                    f_out_next     = res_f_reg;
                    sat_out_next   = res_sat_reg;
                    empty_out_next = res_empty_reg;
                    rvalid_next    = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            hw_reg       <= HW_RESET;
            nc_reg       <= NC_RESET;
            step_sum_reg <= '0;
            step_en_reg  <= '0;
            ci_reg       <= '0;
            ptr_reg      <= '0;
            fill_reg     <= '0;
            num_reg      <= '0;
            den_reg      <= '0;
            rvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            hw_reg       <= hw_next;
            nc_reg       <= nc_next;
            step_sum_reg <= step_sum_next;
            step_en_reg  <= step_en_next;
            ci_reg       <= ci_next;
            ptr_reg      <= ptr_next;
            fill_reg     <= fill_next;
            num_reg      <= num_next;
            den_reg      <= den_next;
            rvalid_reg   <= rvalid_next;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        seg_reg       <= seg_next;
        xsq_reg       <= xsq_next;
        new_sq_reg    <= new_sq_next;
        new_en_reg    <= new_en_next;
        sub_reg       <= sub_next;
        nd_reg        <= nd_next;
        fdvd_reg      <= fdvd_next;
        fdsor_reg     <= fdsor_next;
        div_rem_reg   <= div_rem_next;
        div_dsh_reg   <= div_dsh_next;
        div_q_reg     <= div_q_next;
        div_pos_reg   <= div_pos_next;
        res_semb_reg  <= res_semb_next;
        res_f_reg     <= res_f_next;
        res_sat_reg   <= res_sat_next;
        res_empty_reg <= res_empty_next;
        semb_out_reg  <= semb_out_next;
        f_out_reg     <= f_out_next;
        sat_out_reg   <= sat_out_next;
        empty_out_reg <= empty_out_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A new result beat only comes from the output hand-off state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == S_OUT))
        else $error("result beat raised outside the output hand-off");

    // A free output register takes the result and the sequencer goes idle
    a_out_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_free) |=> (result_valid && state_reg == S_IDLE))
        else $error("result not handed off to a free output register");

    // Ring pointer stays inside the ring
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_W'(MAX_WINDOW - 1))
        else $error("ring pointer out of range");

    // Restoring divider keeps its partial remainder below twice the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FDIV && div_pos_reg != POS_W'(F_QBITS)) ||
         (state_reg == S_SDIV && div_pos_reg != POS_W'(SEMB_FRAC)))
        |-> (DSH_W'(div_rem_reg) < (div_dsh_reg << 1)))
        else $error("divider remainder out of bounds");

    // An empty window carries zero semblance and F, no saturation
    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && empty_window)
        |-> (semblance == '0 && f_statistic == '0 && !f_saturated))
        else $error("empty window result with nonzero fields");

endmodule

`default_nettype wire

/* hdl/msfs_ram.sv */
// ============================================================================
// msfs_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module msfs_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
